FILE: src/lif_neuron_q16_mac_defines.svh
// Assertion macros shared by the neuron RTL.
// Both sample on i_clk and stay quiet while i_rst_n is low.
`ifndef LIF_NEURON_Q16_MAC_DEFINES_SVH
`define LIF_NEURON_Q16_MAC_DEFINES_SVH

// Same-cycle implication.
`define LNQ_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("lnq assertion failed");

// Next-cycle implication.
`define LNQ_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("lnq assertion failed");

`endif

FILE: src/lnq_pkg.sv
// Shared types and constants for the Q16.16 neuron.
// No dependencies; imported by every module of the block but lnq_mul.
package lnq_pkg;

    localparam int unsigned CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SPIKE_CAP = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SEED      = 2'd2;

    localparam logic [63:0] GEN_GOLDEN = 64'h9e3779b97f4a7c15;
    localparam logic [63:0] GEN_MIX1   = 64'hbf58476d1ce4e5b9;
    localparam logic [63:0] GEN_MIX2   = 64'h94d049bb133111eb;
    localparam logic [63:0] SEED_RESET = 64'h123456789abce900;

    localparam logic [24:0] WEIGHT_OFFSET = 25'h07FFFFF;
    localparam logic [30:0] THRESH_RESET  = 31'd32768;
    localparam logic [15:0] CAP_RESET     = 16'd15;

    localparam logic [31:0] Q_MAX = 32'h7FFFFFFF;
    localparam logic [31:0] Q_MIN = 32'h80000000;

    // Hash sequence: two rounds of three partial products each.
    localparam logic [3:0] STEP_MIX_Z = 4'd4;
    localparam logic [3:0] STEP_ROUND2 = 4'd5;
    localparam logic [3:0] STEP_LAST = 4'd9;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_HASH  = 7'b0000010,
        S_PROD  = 7'b0000100,
        S_ROUND = 7'b0001000,
        S_CLAMP = 7'b0010000,
        S_ACCUM = 7'b0100000,
        S_FIRE  = 7'b1000000
    } t_state;

    typedef struct packed {
        logic       idle;
        logic       hash;
        logic [3:0] step;
        logic       prod;
        logic       round;
        logic       clamp;
        logic       accum;
        logic       fire_go;
    } t_ctrl;

endpackage

FILE: src/lnq_mul.sv
// Shared 32x32 unsigned multiplier with a registered 64-bit product.
// Standalone; used by the neuron datapath for every multiply.
module lnq_mul (
    input  logic        i_clk,
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    output logic [63:0] o_prod
);
    logic [63:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= 64'(i_a) * 64'(i_b);
    end

    assign o_prod = r_prod;
endmodule

FILE: src/lnq_ctrl.sv
// Sequencer for the neuron: walks the hash, product, rounding, clamp,
// accumulate and fire steps. Depends on lnq_pkg.
module lnq_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic           i_out_free,
    output lnq_pkg::t_ctrl o_ctrl
);
    import lnq_pkg::*;

    t_state     r_state, n_state;
    logic [3:0] r_step, n_step;

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        case (r_state)
            S_IDLE: begin
                n_step = '0;
                if (i_start) n_state = S_HASH;
            end
            S_HASH: begin
                if (r_step == STEP_LAST) n_state = S_PROD;
                else n_step = r_step + 4'd1;
            end
            S_PROD:  n_state = S_ROUND;
            S_ROUND: n_state = S_CLAMP;
            S_CLAMP: n_state = S_ACCUM;
            S_ACCUM: n_state = S_FIRE;
            S_FIRE: begin
                if (i_out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    assign o_ctrl.idle    = (r_state == S_IDLE);
    assign o_ctrl.hash    = (r_state == S_HASH);
    assign o_ctrl.step    = r_step;
    assign o_ctrl.prod    = (r_state == S_PROD);
    assign o_ctrl.round   = (r_state == S_ROUND);
    assign o_ctrl.clamp   = (r_state == S_CLAMP);
    assign o_ctrl.accum   = (r_state == S_ACCUM);
    assign o_ctrl.fire_go = (r_state == S_FIRE) && i_out_free;
endmodule

FILE: src/lif_neuron_q16_mac.sv
// Q16.16 integrate-and-fire neuron with a splitmix64 synaptic weight.
// Depends on lnq_pkg, lnq_ctrl, lnq_mul and lif_neuron_q16_mac_defines.svh.
//
// Usage:
//   Input channel: i_valid / o_stall with i_stimulus. A request is taken at a
//   rising edge with i_valid high and o_stall low. o_stall is low only while
//   the sequencer is idle, so one request is in flight at a time.
//   Output channel: o_valid / i_stall with the result fields. A result is
//   taken at an edge with o_valid high and i_stall low; while i_stall is high
//   the result holds unchanged.
//   Config channel: i_cfg_valid / o_cfg_ready (always high), i_cfg_index,
//   i_cfg_data. Index 0 threshold, 1 spike cap, 2 seed (also reloads the
//   generator). Other indexes are dropped. Write only while idle.
// Timing:
//   A request runs through the hash steps, in which the single 32x32
//   multiplier computes six partial products for two 64-bit mixing
//   multiplies, one stimulus-by-weight multiply, then round, clamp,
//   accumulate and fire steps. o_valid rises as the fire step ends, and
//   the sequencer idles for the next request. The finished result sits in
//   its own register, so a new request may start while it waits; a second
//   result waits in the fire step until the first is taken.
// Reset (synchronous, i_rst_n low): accumulator, spike count and sticky
//   flags clear, registers return to defaults, generator loads the seed.
module lif_neuron_q16_mac (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // input channel
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic signed [31:0]           i_stimulus,
    // output channel
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic                         o_spike,
    output logic signed [24:0]           o_drawn_weight,
    output logic signed [31:0]           o_accumulator_value,
    output logic                         o_saturated,
    output logic                         o_truncated,
    output logic                         o_burst_cropped,
    output logic [2:0]                   o_sticky_flags,
    // config channel
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [lnq_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [63:0]                  i_cfg_data
);
    import lnq_pkg::*;

    `include "lif_neuron_q16_mac_defines.svh"

    t_ctrl ctrl;

    // configuration and architectural state
    logic [30:0] r_thresh;
    logic [15:0] r_cap;
    logic [63:0] r_gen;
    logic [31:0] r_acc;
    logic [15:0] r_count;
    logic [2:0]  r_hist;

    // working registers
    logic [63:0] r_z;
    logic [63:0] r_mac;
    logic [31:0] r_smag;
    logic        r_sneg;
    logic [24:0] r_w;
    logic [39:0] r_qm;
    logic [31:0] r_p;
    logic        r_sat;
    logic        r_trunc;

    // output register
    logic        r_out_valid;
    logic        r_out_spike;
    logic [24:0] r_out_w;
    logic [31:0] r_out_acc;
    logic        r_out_sat;
    logic        r_out_trunc;
    logic        r_out_crop;
    logic [2:0]  r_out_hist;

    logic        start;
    logic        cfg_we;
    logic        out_free;
    logic [63:0] gen_next;
    logic [63:0] k_sel;
    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [63:0] prod;
    logic [63:0] raw;
    logic [23:0] w_mag;
    logic        p_neg;
    logic [15:0] low16;
    logic        rnd_a;
    logic        rnd_up;
    logic [32:0] sum;
    logic [31:0] acc_abs;
    logic        reach;
    logic        crop;
    logic        fire;

    assign start    = i_valid && ctrl.idle;
    assign cfg_we   = i_cfg_valid;
    assign out_free = !r_out_valid || !i_stall;
    assign o_stall  = !ctrl.idle;
    assign o_cfg_ready = 1'b1;

    lnq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_out_free (out_free),
        .o_ctrl     (ctrl)
    );

    // Operand select for the shared multiplier. Hash round one uses steps
    // 0..2, round two steps 5..7: low*low, low*high, high*low.
    assign k_sel = (ctrl.step < STEP_ROUND2) ? GEN_MIX1 : GEN_MIX2;
    assign w_mag = r_w[24] ? 24'(-r_w) : r_w[23:0];

    always_comb begin
        if (ctrl.prod) begin
            mul_a = r_smag;
            mul_b = 32'(w_mag);
        end else begin
            mul_a = (ctrl.step == 4'd2 || ctrl.step == 4'd7) ? r_z[63:32] : r_z[31:0];
            mul_b = (ctrl.step == 4'd1 || ctrl.step == 4'd6) ? k_sel[63:32] : k_sel[31:0];
        end
    end

    lnq_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (prod)
    );

    assign gen_next = r_gen + GEN_GOLDEN;
    assign raw      = r_mac ^ (r_mac >> 31);

    // Rounding: magnitude quotient, plus one when the floor of a negative
    // product moves away from zero, plus the guard/round/sticky increment.
    assign p_neg  = r_sneg ^ r_w[24];
    assign low16  = prod[15:0];
    assign rnd_a  = p_neg && (low16 != 16'd0);
    assign rnd_up = low16[15] && (low16[14] || (low16[12:0] != 13'd0) || (prod[16] ^ rnd_a));

    assign sum = {r_acc[31], r_acc} + {r_p[31], r_p};

    assign acc_abs = r_acc[31] ? (-r_acc) : r_acc;
    // wrapped abs: the most negative value never fires
    assign reach = (r_acc != Q_MIN) && (acc_abs[30:0] >= r_thresh);
    assign crop  = reach && (r_count >= r_cap);
    assign fire  = reach && !crop;

    // control and architectural state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thresh    <= THRESH_RESET;
            r_cap       <= CAP_RESET;
            r_gen       <= SEED_RESET;
            r_acc       <= '0;
            r_count     <= '0;
            r_hist      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (cfg_we) begin
                case (i_cfg_index)
                    CFG_THRESHOLD: r_thresh <= i_cfg_data[30:0];
                    CFG_SPIKE_CAP: r_cap    <= i_cfg_data[15:0];
                    CFG_SEED:      r_gen    <= i_cfg_data;
                    default:       ;
                endcase
            end else if (start) begin
                r_gen <= gen_next;
            end

            if (ctrl.accum) begin
                if (sum[32] != sum[31]) r_acc <= sum[32] ? Q_MIN : Q_MAX;
                else r_acc <= sum[31:0];
            end

            if (ctrl.fire_go) begin
                if (fire) r_count <= r_count + 16'd1;
                r_hist      <= r_hist | {crop, r_trunc, r_sat};
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (start) begin
            r_z     <= gen_next ^ (gen_next >> 30);
            r_smag  <= i_stimulus[31] ? (-i_stimulus) : i_stimulus;
            r_sneg  <= i_stimulus[31];
            r_sat   <= 1'b0;
            r_trunc <= 1'b0;
        end

        if (ctrl.hash) begin
            case (ctrl.step)
                4'd1, 4'd6:             r_mac <= prod;
                4'd2, 4'd3, 4'd7, 4'd8: r_mac[63:32] <= r_mac[63:32] + prod[31:0];
                STEP_MIX_Z:             r_z <= r_mac ^ (r_mac >> 27);
                STEP_LAST:              r_w <= {1'b0, raw[23:0]} - WEIGHT_OFFSET;
                default:                ;
            endcase
        end

        if (ctrl.round) begin
            r_qm    <= prod[55:16] + 40'(rnd_a) + 40'(rnd_up);
            r_trunc <= (low16 != 16'd0);
        end

        if (ctrl.clamp) begin
            if (!p_neg) begin
                if (r_qm > 40'(Q_MAX)) begin
                    r_p   <= Q_MAX;
                    r_sat <= 1'b1;
                end else begin
                    r_p <= r_qm[31:0];
                end
            end else begin
                if (r_qm > 40'(Q_MIN)) begin
                    r_p   <= Q_MIN;
                    r_sat <= 1'b1;
                end else begin
                    r_p <= -r_qm[31:0];
                end
            end
        end

        if (ctrl.accum && (sum[32] != sum[31])) r_sat <= 1'b1;

        if (ctrl.fire_go) begin
            r_out_spike <= fire;
            r_out_w     <= r_w;
            r_out_acc   <= r_acc;
            r_out_sat   <= r_sat;
            r_out_trunc <= r_trunc;
            r_out_crop  <= crop;
            r_out_hist  <= r_hist | {crop, r_trunc, r_sat};
        end
    end

    assign o_valid             = r_out_valid;
    assign o_spike             = r_out_spike;
    assign o_drawn_weight      = r_out_w;
    assign o_accumulator_value = r_out_acc;
    assign o_saturated         = r_out_sat;
    assign o_truncated         = r_out_trunc;
    assign o_burst_cropped     = r_out_crop;
    assign o_sticky_flags      = r_out_hist;

    `LNQ_ASSERT_NOW(a_spike_or_crop, o_valid, !(o_spike && o_burst_cropped))
    `LNQ_ASSERT_NOW(a_sticky_covers, o_valid, (o_sticky_flags & {o_burst_cropped, o_truncated, o_saturated}) == {o_burst_cropped, o_truncated, o_saturated})
    `LNQ_ASSERT_NOW(a_no_fire_at_min, o_valid && o_spike, o_accumulator_value != Q_MIN)
    `LNQ_ASSERT_NEXT(a_start_hash, i_valid && !o_stall, ctrl.hash && ctrl.step == 4'd0)

endmodule

FILE: dv/lnq_scoreboard.sv
`timescale 1ns / 1ps
// Scoreboard for lif_neuron_q16_mac: watches the request, result and register
// channels, predicts each result from its own copy of the neuron state and
// compares it. Depends on lnq_pkg for register indexes and generator constants.
module lnq_scoreboard (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_req_valid,
    input  logic                          i_req_stall,
    input  logic signed [31:0]            i_stimulus,
    input  logic                          i_res_valid,
    input  logic                          i_res_stall,
    input  logic                          i_spike,
    input  logic signed [24:0]            i_drawn_weight,
    input  logic signed [31:0]            i_accumulator_value,
    input  logic                          i_saturated,
    input  logic                          i_truncated,
    input  logic                          i_burst_cropped,
    input  logic [2:0]                    i_sticky_flags,
    input  logic                          i_cfg_valid,
    input  logic                          i_cfg_ready,
    input  logic [lnq_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [63:0]                   i_cfg_data,
    output int                            o_fail_count,
    output int                            o_pending
);
    import lnq_pkg::*;

    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic               spike;
        logic signed [24:0] weight;
        logic signed [31:0] acc;
        logic               sat;
        logic               trunc;
        logic               crop;
        logic [2:0]         sticky;
    } t_step_result;

    // model copy of registers and neuron state
    logic [30:0]        thresh_q;
    logic [15:0]        cap_q;
    logic signed [31:0] acc_q;
    logic [15:0]        spike_cnt_q;
    logic [63:0]        gen_q;
    logic [2:0]         history_q;

    t_step_result neuron_results_q[$];
    int           fails;

    initial fails = 0;

    function automatic longint clamp_q16(input longint v, output logic hit);
        hit = 1'b0;
        if (v > longint'(Q_MAX)) begin
            hit = 1'b1;
            return longint'(Q_MAX);
        end
        if (v < longint'($signed(Q_MIN))) begin
            hit = 1'b1;
            return longint'($signed(Q_MIN));
        end
        return v;
    endfunction

    // One neuron step: draw a weight, multiply with rounding, accumulate, fire.
    function automatic t_step_result neuron_step(input logic signed [31:0] stim);
        logic [63:0]  z;
        logic [63:0]  mag;
        logic [15:0]  low16;
        longint       wgt;
        longint       prod;
        longint       q;
        longint       sum;
        longint       sum_mag;
        logic         neg;
        logic         rnd_away;
        logic         sat_prod;
        logic         sat_sum;
        t_step_result r;
        gen_q = gen_q + GEN_GOLDEN;
        z = gen_q;
        z = (z ^ (z >> 30)) * GEN_MIX1;
        z = (z ^ (z >> 27)) * GEN_MIX2;
        z = z ^ (z >> 31);
        wgt = longint'(z[23:0]) - longint'(WEIGHT_OFFSET);

        prod  = longint'(stim) * wgt;
        neg   = prod < 0;
        mag   = neg ? 64'(-prod) : 64'(prod);
        low16 = mag[15:0];
        // floor quotient, then round away from zero on guard with round/sticky/odd
        if (neg) q = -longint'((mag + 64'hFFFF) >> 16);
        else q = longint'(mag >> 16);
        rnd_away = low16[15] && (low16[14] || (low16[12:0] != 13'd0) || q[0]);
        if (rnd_away) q = neg ? q - 1 : q + 1;
        q = clamp_q16(q, sat_prod);

        sum   = clamp_q16(longint'(acc_q) + q, sat_sum);
        acc_q = sum[31:0];

        r        = '0;
        r.weight = wgt[24:0];
        r.acc    = acc_q;
        r.sat    = sat_prod | sat_sum;
        r.trunc  = low16 != 16'd0;
        // wrapped absolute value: the most negative sum never fires
        sum_mag = (sum < 0) ? -sum : sum;
        if (sum_mag <= longint'(Q_MAX) && sum_mag >= longint'(thresh_q)) begin
            if (spike_cnt_q >= cap_q) begin
                r.crop = 1'b1;
            end else begin
                spike_cnt_q = spike_cnt_q + 16'd1;
                r.spike = 1'b1;
            end
        end
        history_q = history_q | {r.crop, r.trunc, r.sat};
        r.sticky  = history_q;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_step_result got;
        t_step_result want;
        if (!i_rst_n) begin
            thresh_q    = THRESH_RESET;
            cap_q       = CAP_RESET;
            acc_q       = '0;
            spike_cnt_q = '0;
            gen_q       = SEED_RESET;
            history_q   = '0;
            neuron_results_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_THRESHOLD: thresh_q = i_cfg_data[30:0];
                    CFG_SPIKE_CAP: cap_q = i_cfg_data[15:0];
                    CFG_SEED:      gen_q = i_cfg_data;
                    default: ;
                endcase
            end

            if (i_res_valid && !i_res_stall) begin
                got = {i_spike, i_drawn_weight, i_accumulator_value, i_saturated,
                       i_truncated, i_burst_cropped, i_sticky_flags};
                if (neuron_results_q.size() == 0) begin
                    if (fails < MAX_REPORTS)
                        $display("%0t: result with no request pending", $time);
                    fails++;
                end else begin
                    want = neuron_results_q.pop_front();
                    if (got !== want) begin
                        if (fails < MAX_REPORTS) begin
                            $display("%0t: mismatch expected spike=%0b w=%0d acc=%0d sat=%0b trunc=%0b crop=%0b sticky=%0b",
                                     $time, want.spike, want.weight, want.acc, want.sat,
                                     want.trunc, want.crop, want.sticky);
                            $display("%0t:          actual   spike=%0b w=%0d acc=%0d sat=%0b trunc=%0b crop=%0b sticky=%0b",
                                     $time, got.spike, got.weight, got.acc, got.sat,
                                     got.trunc, got.crop, got.sticky);
                        end
                        fails++;
                    end
                end
            end

            if (i_req_valid && !i_req_stall)
                neuron_results_q.insert(neuron_results_q.size(), neuron_step(i_stimulus));
        end
        o_pending    <= neuron_results_q.size();
        o_fail_count <= fails;
    end

endmodule

FILE: dv/tb_lif_neuron_q16_mac.sv
`timescale 1ns / 1ps
// Top of the lif_neuron_q16_mac testbench: clock, reset, request and register
// stimulus, result back-pressure and the verdict. Depends on lnq_pkg, the
// block itself and lnq_scoreboard, which does all prediction and checking.
module tb_lif_neuron_q16_mac;
    import lnq_pkg::*;

    // index 3 is not decoded by the block; writes to it must be dropped
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    localparam int NUM_PHASES      = 8;
    localparam int ITEMS_PER_PHASE = 135;
    localparam int QUIET_PHASE     = 2;   // no idling on either side
    localparam int HOLD_PHASE      = 5;   // receiver holds off for a long stretch
    localparam int HOLD_CYCLES     = 400;
    localparam int IDLE_PCT        = 32;
    localparam int TAIL_CYCLES     = 20;  // a bit more than one request's latency
    localparam int TIMEOUT_NS      = 2_000_000;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               req_valid;
    logic               req_stall;
    logic signed [31:0] stimulus;
    logic               res_valid;
    logic               res_stall;
    logic               spike;
    logic signed [24:0] drawn_weight;
    logic signed [31:0] acc_value;
    logic               saturated;
    logic               truncated;
    logic               burst_cropped;
    logic [2:0]         sticky_flags;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [63:0]        cfg_data;
    int                 fail_count;
    int                 pending;

    // stimulus knobs, changed only at the falling edge by nonblocking writes
    logic idle_en;
    logic hold_req;
    // set and cleared at the rising edge, read at the falling edge
    logic hold_active;

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    lif_neuron_q16_mac DUT (
        .i_clk               (clk),
        .i_rst_n             (rst_n),
        .i_valid             (req_valid),
        .o_stall             (req_stall),
        .i_stimulus          (stimulus),
        .o_valid             (res_valid),
        .i_stall             (res_stall),
        .o_spike             (spike),
        .o_drawn_weight      (drawn_weight),
        .o_accumulator_value (acc_value),
        .o_saturated         (saturated),
        .o_truncated         (truncated),
        .o_burst_cropped     (burst_cropped),
        .o_sticky_flags      (sticky_flags),
        .i_cfg_valid         (cfg_valid),
        .o_cfg_ready         (cfg_ready),
        .i_cfg_index         (cfg_index),
        .i_cfg_data          (cfg_data)
    );

    lnq_scoreboard u_scoreboard (
        .i_clk               (clk),
        .i_rst_n             (rst_n),
        .i_req_valid         (req_valid),
        .i_req_stall         (req_stall),
        .i_stimulus          (stimulus),
        .i_res_valid         (res_valid),
        .i_res_stall         (res_stall),
        .i_spike             (spike),
        .i_drawn_weight      (drawn_weight),
        .i_accumulator_value (acc_value),
        .i_saturated         (saturated),
        .i_truncated         (truncated),
        .i_burst_cropped     (burst_cropped),
        .i_sticky_flags      (sticky_flags),
        .i_cfg_valid         (cfg_valid),
        .i_cfg_ready         (cfg_ready),
        .i_cfg_index         (cfg_index),
        .i_cfg_data          (cfg_data),
        .o_fail_count        (fail_count),
        .o_pending           (pending)
    );

    // Offer one request; called and returning at a falling edge. Valid stays
    // high from one request to the next unless an idle cycle falls between.
    task automatic push_stimulus(input logic [31:0] value);
        // close any register write left open by write_reg
        cfg_valid <= 1'b0;
        while (idle_en && $urandom_range(99) < IDLE_PCT) begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req_valid <= 1'b1;
        stimulus  <= value;
        // hold the request until a rising edge sees stall low
        @(posedge clk);
        while (req_stall) @(posedge clk);
        @(negedge clk);
    endtask

    // Write one register; valid is left high so back-to-back writes need no
    // second assignment in one step. push_stimulus drops it.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input logic [63:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        @(negedge clk);
    endtask

    // Stop offering requests and wait until every expected result is in.
    // Each request yields exactly one result, so the block is idle then.
    task automatic drain();
        req_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
    endtask

    // Mostly scaled values so the accumulator wanders instead of pinning.
    function automatic logic [31:0] draw_stimulus();
        logic [31:0] v;
        case ($urandom_range(9))
            0: v = $urandom;
            1: begin
                case ($urandom_range(4))
                    0: v = 32'h7FFFFFFF;
                    1: v = 32'h80000000;
                    2: v = 32'h00000000;
                    3: v = 32'hFFFFFFFF;
                    default: v = 32'h00000001;
                endcase
            end
            default: begin
                v = $urandom >> $urandom_range(31);
                if ($urandom_range(1) == 1) v = -v;
            end
        endcase
        return v;
    endfunction

    // Pick a new register setting between phases; all registers on the first.
    task automatic retune(input bit write_all);
        logic [63:0] data;
        drain();
        if (write_all || $urandom_range(1) == 1) begin
            data = {$urandom, $urandom};
            case ($urandom_range(4))
                0: data[30:0] = '0;
                1: data[30:0] = 31'd1;
                2: data[30:0] = 31'h7FFFFFFF;
                default: data[30:0] = 31'($urandom >> $urandom_range(1, 31));
            endcase
            write_reg(CFG_THRESHOLD, data);
        end
        if (write_all || $urandom_range(1) == 1) begin
            data = {$urandom, $urandom};
            case ($urandom_range(4))
                0: data[15:0] = '0;
                1: data[15:0] = 16'hFFFF;
                2: data[15:0] = 16'($urandom_range(0, 40));
                default: data[15:0] = 16'($urandom_range(0, 65535));
            endcase
            write_reg(CFG_SPIKE_CAP, data);
        end
        if (write_all || $urandom_range(1) == 1) begin
            case ($urandom_range(5))
                0: data = '0;
                1: data = '1;
                default: data = {$urandom, $urandom};
            endcase
            write_reg(CFG_SEED, data);
        end
        if ($urandom_range(3) == 0) write_reg(CFG_UNUSED, {$urandom, $urandom});
    endtask

    // Result side: random back-pressure, plus the long hold-off.
    initial begin
        res_stall = 1'b0;
        forever begin
            @(negedge clk);
            res_stall <= hold_active || (idle_en && $urandom_range(99) < IDLE_PCT);
        end
    end

    // Long hold-off, counted here so the request side keeps offering and
    // the block fills its result register, then its fire step, then stalls.
    initial begin
        hold_active = 1'b0;
        @(posedge hold_req);
        @(posedge clk);
        hold_active = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_active = 1'b0;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("lif_neuron_q16_mac test failed");
        $finish;
    end

    initial begin
        rst_n     = 1'b0;
        req_valid = 1'b0;
        stimulus  = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        idle_en   = 1'b1;
        hold_req  = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset defaults: zero, unit steps, extremes and a half-LSB stimulus.
        push_stimulus(32'h00000000);
        push_stimulus(32'h00000001);
        push_stimulus(32'hFFFFFFFF);
        push_stimulus(32'h7FFFFFFF);
        push_stimulus(32'h80000000);
        push_stimulus(32'h00010000);
        push_stimulus(32'hFFFF0000);
        push_stimulus(32'h00008000);
        push_stimulus(32'h00000003);

        // Threshold zero with cap zero: every reach of the threshold is
        // cropped, and extreme stimuli pin the sum at both rails, where the
        // most negative value must neither fire nor crop.
        drain();
        write_reg(CFG_THRESHOLD, 64'h0);
        write_reg(CFG_SPIKE_CAP, 64'h0);
        push_stimulus(32'h7FFFFFFF);
        push_stimulus(32'h7FFFFFFF);
        push_stimulus(32'h80000000);
        push_stimulus(32'h80000000);
        push_stimulus(32'h7FFFFFFF);
        push_stimulus(32'h80000000);

        // Largest threshold and cap, zero seed; the unused index is dropped.
        drain();
        write_reg(CFG_UNUSED, 64'hFFFFFFFFFFFFFFFF);
        write_reg(CFG_SEED, 64'h0);
        write_reg(CFG_SPIKE_CAP, 64'hFFFFFFFFFFFFFFFF);
        write_reg(CFG_THRESHOLD, 64'hFFFFFFFFFFFFFFFF);
        push_stimulus(32'h7FFFFFFF);
        push_stimulus(32'h80000000);
        push_stimulus(32'h80000000);
        push_stimulus(32'h00000001);

        // All-ones seed with the smallest nonzero threshold.
        drain();
        write_reg(CFG_SEED, 64'hFFFFFFFFFFFFFFFF);
        write_reg(CFG_THRESHOLD, 64'h1);
        push_stimulus(32'h00000001);
        push_stimulus(32'hFFFFFFFF);
        push_stimulus(32'h40000000);

        // Random phases, each under its own register setting.
        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            retune(phase == 0);
            idle_en  <= (phase != QUIET_PHASE);
            hold_req <= (phase == HOLD_PHASE);
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
                push_stimulus(draw_stimulus());
        end

        // Wait out every result, then a request's latency for stray output.
        drain();
        repeat (TAIL_CYCLES) @(negedge clk);
        if (fail_count == 0) begin
            $display("lif_neuron_q16_mac test passed");
        end else begin
            $display("lif_neuron_q16_mac test failed");
        end
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+src
src/lnq_pkg.sv
src/lnq_mul.sv
src/lnq_ctrl.sv
src/lif_neuron_q16_mac.sv
dv/lnq_scoreboard.sv
dv/tb_lif_neuron_q16_mac.sv
